// ----- rtl/core/sss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and codes of the SMTP session sequencer: verb codes, reply
// codes, body characters and the result records that pass to the queue.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam logic [3:0] VERB_QUIT      = 4'd0;
  localparam logic [3:0] VERB_HELO      = 4'd1;
  localparam logic [3:0] VERB_EHLO      = 4'd2;
  localparam logic [3:0] VERB_XFWD_NAME = 4'd3;
  localparam logic [3:0] VERB_XFWD_PROT = 4'd4;
  localparam logic [3:0] VERB_MAIL      = 4'd5;
  localparam logic [3:0] VERB_RCPT      = 4'd6;
  localparam logic [3:0] VERB_DATA      = 4'd7;
  localparam logic [3:0] VERB_RSET      = 4'd8;
  localparam logic [3:0] VERB_NOOP      = 4'd9;
  localparam logic [3:0] VERB_EMPTY     = 4'd11;

  localparam logic [9:0] REPLY_NONE     = 10'd0;
  localparam logic [9:0] REPLY_BYE      = 10'd221;
  localparam logic [9:0] REPLY_OK       = 10'd250;
  localparam logic [9:0] REPLY_START    = 10'd354;
  localparam logic [9:0] REPLY_SYNTAX   = 10'd500;
  localparam logic [9:0] REPLY_BAD_ARG  = 10'd501;
  localparam logic [9:0] REPLY_UNKNOWN  = 10'd502;
  localparam logic [9:0] REPLY_SEQUENCE = 10'd503;
  localparam logic [9:0] REPLY_FAILED   = 10'd554;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_DOT = 8'h2E;

  typedef struct packed {
    logic       reply_valid;
    logic [9:0] reply_code;
    logic       body_valid;
    logic [7:0] body_out;
    logic       data_end;
    logic [7:0] recipients;
    logic       last;
  } sss_result_t;

  typedef struct packed {
    sss_result_t first;
    sss_result_t second;
    logic        pair;
  } sss_step_t;

endpackage

// ----- rtl/core/sss_session.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_session
// Session state, recipient count and body unstuffing. Turns the registered
// item into one or two result records and updates state when it advances.
// ----------------------------------------------------------------------------
module sss_session #(
  parameter int unsigned RCPT_LIMIT = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               command,
  input  logic [3:0]         verb,
  input  logic               arg_ok,
  input  logic [7:0]         body_byte,
  output sss_pkg::sss_step_t step
);
  import sss_pkg::*;

  localparam logic [7:0] RCPT_CAP = (RCPT_LIMIT < 255) ? 8'(RCPT_LIMIT) : 8'd255;

  typedef enum logic [2:0] {
    ST_INIT, ST_HELO, ST_XFWD, ST_MAIL, ST_RCPT, ST_DATA, ST_QUIT
  } state_t;

  state_t     state, state_next;
  logic [7:0] rcpt_total, rcpt_total_next;
  logic       in_body, in_body_next;
  logic       at_line_start, at_line_start_next;
  logic       held_dot, held_dot_next;
  logic       held_cr, held_cr_next;

  logic [9:0] code;
  logic       bv;
  logic [7:0] bo;
  logic       de;
  logic       pair;

  function automatic sss_result_t make_result(logic [9:0] c, logic v, logic [7:0] b,
                                              logic e, logic [7:0] n, logic l);
    sss_result_t r;
    r.reply_valid = (c != REPLY_NONE);
    r.reply_code  = c;
    r.body_valid  = v;
    r.body_out    = v ? b : 8'd0;
    r.data_end    = e;
    r.recipients  = n;
    r.last        = l;
    return r;
  endfunction

  always_comb begin
    state_next         = state;
    rcpt_total_next    = rcpt_total;
    in_body_next       = in_body;
    at_line_start_next = at_line_start;
    held_dot_next      = held_dot;
    held_cr_next       = held_cr;
    code               = REPLY_NONE;
    bv                 = 1'b0;
    bo                 = 8'd0;
    de                 = 1'b0;
    pair               = 1'b0;
    if (state == ST_QUIT || command != in_body) begin
      code = REPLY_NONE;
    end else if (command) begin
      if (held_cr) begin
        held_cr_next = 1'b0;
        if (body_byte == CHAR_LF) begin
          in_body_next       = 1'b0;
          at_line_start_next = 1'b1;
          code               = REPLY_OK;
          de                 = 1'b1;
        end else begin
          bv   = 1'b1;
          bo   = CHAR_CR;
          pair = 1'b1;
        end
      end else if (held_dot) begin
        held_dot_next = 1'b0;
        if (body_byte == CHAR_LF) begin
          in_body_next       = 1'b0;
          at_line_start_next = 1'b1;
          code               = REPLY_OK;
          de                 = 1'b1;
        end else if (body_byte == CHAR_CR) begin
          held_cr_next = 1'b1;
        end else begin
          bv = 1'b1;
          bo = body_byte;
        end
      end else if (at_line_start && body_byte == CHAR_DOT) begin
        held_dot_next      = 1'b1;
        at_line_start_next = 1'b0;
      end else begin
        at_line_start_next = (body_byte == CHAR_LF);
        bv                 = 1'b1;
        bo                 = body_byte;
      end
    end else begin
      unique case (verb)
        VERB_QUIT: begin
          state_next = ST_QUIT;
          code       = REPLY_BYE;
        end
        VERB_HELO, VERB_EHLO: begin
          if (state != ST_INIT) rcpt_total_next = 8'd0;
          if (arg_ok) begin
            state_next = ST_HELO;
            code       = REPLY_OK;
          end else begin
            code = REPLY_BAD_ARG;
          end
        end
        VERB_XFWD_NAME, VERB_XFWD_PROT: begin
          state_next = ST_XFWD;
          code       = REPLY_OK;
        end
        VERB_MAIL: begin
          if (state == ST_MAIL) begin
            code = REPLY_SEQUENCE;
          end else if (!arg_ok) begin
            code = REPLY_BAD_ARG;
          end else begin
            state_next = ST_MAIL;
            code       = REPLY_OK;
          end
        end
        VERB_RCPT: begin
          if (state != ST_MAIL && state != ST_RCPT) begin
            code = REPLY_SEQUENCE;
          end else if (!arg_ok) begin
            code = REPLY_BAD_ARG;
          end else begin
            if (rcpt_total < RCPT_CAP) rcpt_total_next = rcpt_total + 8'd1;
            state_next = ST_RCPT;
            code       = REPLY_OK;
          end
        end
        VERB_DATA: begin
          if (state == ST_RCPT) begin
            state_next         = ST_DATA;
            in_body_next       = 1'b1;
            at_line_start_next = 1'b1;
            held_dot_next      = 1'b0;
            held_cr_next       = 1'b0;
            code               = REPLY_START;
          end else if (state == ST_MAIL) begin
            code = REPLY_FAILED;
          end else begin
            code = REPLY_SEQUENCE;
          end
        end
        VERB_RSET: begin
          rcpt_total_next = 8'd0;
          state_next      = ST_INIT;
          code            = REPLY_OK;
        end
        VERB_NOOP:  code = REPLY_OK;
        VERB_EMPTY: code = REPLY_SYNTAX;
        default:    code = REPLY_UNKNOWN;
      endcase
    end
    step.first  = make_result(code, bv, bo, de, rcpt_total_next, !pair);
    step.second = make_result(REPLY_NONE, 1'b1, body_byte, 1'b0, rcpt_total_next, 1'b1);
    step.pair   = pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      rcpt_total    <= 8'd0;
      in_body       <= 1'b0;
      at_line_start <= 1'b1;
      held_dot      <= 1'b0;
      held_cr       <= 1'b0;
    end else if (advance) begin
      state         <= state_next;
      rcpt_total    <= rcpt_total_next;
      in_body       <= in_body_next;
      at_line_start <= at_line_start_next;
      held_dot      <= held_dot_next;
      held_cr       <= held_cr_next;
    end
  end

endmodule

// ----- rtl/core/sss_result_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_result_queue
// Four-entry result queue. Takes one or two records per cycle and hands
// out one record per output beat.
// ----------------------------------------------------------------------------
module sss_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sss_pkg::sss_step_t   step,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sss_pkg::sss_result_t head
);
  import sss_pkg::*;

  sss_result_t entries [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic [2:0]  count_next;
  logic        pop;
  logic [2:0]  push_n;

  assign room      = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];
  assign push_n    = push ? (step.pair ? 3'd2 : 3'd1) : 3'd0;
  assign count_next = count + push_n - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= step.first;
      if (step.pair) entries[wr_ptr + 2'd1] <= step.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count_next;
    end
  end

endmodule

// ----- rtl/core/smtp_server_session_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtp_server_session_sequencer_unit
// Server side of an SMTP session with dot-unstuffing of the message body.
//
// Input channel (in_valid/in_ready): one beat is either a classified
// command (command = 0, verb, arg_ok) or one body byte (command = 1).
// Output channel (out_valid/out_ready): one result beat carries a reply
// code, an unstuffed body byte, the end-of-data flag and the recipient
// count; last marks the final beat of an input item.
// Path: an accepted item lands in the input register, is evaluated there
// and, once the queue has room, is written to the result queue, whose head
// drives the output. Throughput: one item per cycle while the queue has room;
// a held CR released with the next byte makes two output beats.
// A four-entry result queue sets the rate: an item leaves the input
// register only while two entries are free.
// When the receiver stalls, the queue fills and in_ready drops.
// Reset: session in init, no recipients, no body phase, queue empty.
// ----------------------------------------------------------------------------
module smtp_server_session_sequencer_unit #(
  parameter int unsigned RCPT_LIMIT = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [3:0] verb,
  input  logic       arg_ok,
  input  logic [7:0] body_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       reply_valid,
  output logic [9:0] reply_code,
  output logic       body_valid,
  output logic [7:0] body_out,
  output logic       data_end,
  output logic [7:0] recipients,
  output logic       last
);
  import sss_pkg::*;

  logic        item_valid;
  logic        item_command;
  logic [3:0]  item_verb;
  logic        item_arg_ok;
  logic [7:0]  item_byte;
  logic        room;
  logic        advance;
  sss_step_t   step;
  sss_result_t head;

  assign advance  = item_valid && room;
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_command <= command;
      item_verb    <= verb;
      item_arg_ok  <= arg_ok;
      item_byte    <= body_byte;
    end
  end

  sss_session #(
    .RCPT_LIMIT(RCPT_LIMIT)
  ) u_session (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .command  (item_command),
    .verb     (item_verb),
    .arg_ok   (item_arg_ok),
    .body_byte(item_byte),
    .step     (step)
  );

  sss_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (advance),
    .step     (step),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign reply_valid = head.reply_valid;
  assign reply_code  = head.reply_code;
  assign body_valid  = head.body_valid;
  assign body_out    = head.body_out;
  assign data_end    = head.data_end;
  assign recipients  = head.recipients;
  assign last        = head.last;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SMTP session sequencer. Commands and body
// bytes go in through a valid/ready sender with random gaps. Every
// accepted beat is run through a local session and unstuffing predictor,
// and each result beat is compared field by field with the oldest
// expected one. Covers directed command and body cases, recipient
// saturation, a long receiver hold-off, random sessions and the close.
// ----------------------------------------------------------------------------
module tb_top;
  import sss_pkg::*;

  localparam int unsigned RCPT_MAX = 255;
  localparam int unsigned RCPT_CAP = (RCPT_MAX < 255) ? RCPT_MAX : 255;
  localparam logic [3:0] VERB_UNKNOWN    = 4'd10;
  localparam logic [3:0] VERB_UNASSIGNED = 4'd15;
  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [2:0] {
    SES_INIT, SES_HELO, SES_XFWD, SES_MAIL, SES_RCPT, SES_DATA, SES_QUIT
  } session_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = 1'b0;
  logic [3:0] verb = 4'd0;
  logic       arg_ok = 1'b0;
  logic [7:0] body_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       reply_valid;
  logic [9:0] reply_code;
  logic       body_valid;
  logic [7:0] body_out;
  logic       data_end;
  logic [7:0] recipients;
  logic       last;

  session_t    ses_st = SES_INIT;
  logic [7:0]  rcpt_cnt = 8'd0;
  logic        body_phase = 1'b0;
  logic        line_start = 1'b1;
  logic        dot_held = 1'b0;
  logic        cr_held = 1'b0;
  logic        closed_st = 1'b0;
  logic [31:0] stored_bytes = 32'd0;

  sss_result_t expected_q[$];
  sss_result_t head_r;
  int errors = 0;
  int sent_count = 0;
  int cycle_count = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_req = 0;

  always #2 clk = ~clk;

  smtp_server_session_sequencer_unit #(
    .RCPT_LIMIT(RCPT_MAX)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .verb       (verb),
    .arg_ok     (arg_ok),
    .body_byte  (body_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reply_valid(reply_valid),
    .reply_code (reply_code),
    .body_valid (body_valid),
    .body_out   (body_out),
    .data_end   (data_end),
    .recipients (recipients),
    .last       (last)
  );

  task automatic push_expected(logic [9:0] code, logic bv, logic [7:0] b, logic de,
                               logic lst);
    sss_result_t r;
    r.reply_valid = (code != REPLY_NONE);
    r.reply_code  = code;
    r.body_valid  = bv;
    r.body_out    = bv ? b : 8'h00;
    r.data_end    = de;
    r.recipients  = rcpt_cnt;
    r.last        = lst;
    expected_q.push_back(r);
  endtask

  task automatic bump_stored();
    if (stored_bytes != 32'hFFFF_FFFF) stored_bytes++;
  endtask

  function automatic logic [9:0] apply_command(logic [3:0] v, logic a);
    case (v)
      VERB_QUIT: begin
        closed_st = 1'b1;
        ses_st = SES_QUIT;
        return REPLY_BYE;
      end
      VERB_HELO, VERB_EHLO: begin
        if (ses_st != SES_INIT) begin
          rcpt_cnt = 8'd0;
          stored_bytes = 32'd0;
        end
        if (!a) return REPLY_BAD_ARG;
        ses_st = SES_HELO;
        return REPLY_OK;
      end
      VERB_XFWD_NAME, VERB_XFWD_PROT: begin
        ses_st = SES_XFWD;
        return REPLY_OK;
      end
      VERB_MAIL: begin
        if (ses_st == SES_MAIL) return REPLY_SEQUENCE;
        if (!a) return REPLY_BAD_ARG;
        ses_st = SES_MAIL;
        return REPLY_OK;
      end
      VERB_RCPT: begin
        if (ses_st != SES_MAIL && ses_st != SES_RCPT) return REPLY_SEQUENCE;
        if (!a) return REPLY_BAD_ARG;
        if (rcpt_cnt < RCPT_CAP) rcpt_cnt++;
        ses_st = SES_RCPT;
        return REPLY_OK;
      end
      VERB_DATA: begin
        if (ses_st == SES_RCPT) begin
          ses_st = SES_DATA;
          body_phase = 1'b1;
          line_start = 1'b1;
          dot_held = 1'b0;
          cr_held = 1'b0;
          return REPLY_START;
        end
        if (ses_st == SES_MAIL) return REPLY_FAILED;
        return REPLY_SEQUENCE;
      end
      VERB_RSET: begin
        rcpt_cnt = 8'd0;
        stored_bytes = 32'd0;
        ses_st = SES_INIT;
        return REPLY_OK;
      end
      VERB_NOOP:  return REPLY_OK;
      VERB_EMPTY: return REPLY_SYNTAX;
      default:    return REPLY_UNKNOWN;
    endcase
  endfunction

  task automatic predict_body(logic [7:0] b);
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == CHAR_LF) begin
        body_phase = 1'b0;
        line_start = 1'b1;
        push_expected(REPLY_OK, 1'b0, 8'h00, 1'b1, 1'b1);
      end else begin
        bump_stored();
        bump_stored();
        push_expected(REPLY_NONE, 1'b1, CHAR_CR, 1'b0, 1'b0);
        push_expected(REPLY_NONE, 1'b1, b, 1'b0, 1'b1);
      end
    end else if (dot_held) begin
      dot_held = 1'b0;
      if (b == CHAR_LF) begin
        body_phase = 1'b0;
        line_start = 1'b1;
        push_expected(REPLY_OK, 1'b0, 8'h00, 1'b1, 1'b1);
      end else if (b == CHAR_CR) begin
        cr_held = 1'b1;
        push_expected(REPLY_NONE, 1'b0, 8'h00, 1'b0, 1'b1);
      end else begin
        bump_stored();
        push_expected(REPLY_NONE, 1'b1, b, 1'b0, 1'b1);
      end
    end else if (line_start && b == CHAR_DOT) begin
      dot_held = 1'b1;
      line_start = 1'b0;
      push_expected(REPLY_NONE, 1'b0, 8'h00, 1'b0, 1'b1);
    end else begin
      line_start = (b == CHAR_LF);
      bump_stored();
      push_expected(REPLY_NONE, 1'b1, b, 1'b0, 1'b1);
    end
  endtask

  task automatic predict_beat(logic c, logic [3:0] v, logic a, logic [7:0] b);
    logic [9:0] code;
    if (closed_st || (c != body_phase)) begin
      push_expected(REPLY_NONE, 1'b0, 8'h00, 1'b0, 1'b1);
    end else if (c) begin
      predict_body(b);
    end else begin
      code = apply_command(v, a);
      push_expected(code, 1'b0, 8'h00, 1'b0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_beat(command, verb, arg_ok, body_byte);
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat: reply %0d/%0d body %0d/%0d",
                 $time, reply_valid, reply_code, body_valid, body_out,
                 " end %0d rcpt %0d last %0d", data_end, recipients, last);
        errors++;
      end else begin
        head_r = expected_q.pop_front();
        check_field("reply_valid", head_r.reply_valid, reply_valid);
        check_field("reply_code", head_r.reply_code, reply_code);
        check_field("body_valid", head_r.body_valid, body_valid);
        check_field("body_out", head_r.body_out, body_out);
        check_field("data_end", head_r.data_end, data_end);
        check_field("recipients", head_r.recipients, recipients);
        check_field("last", head_r.last, last);
      end
    end
  end

  initial begin : receiver
    int gap;
    int hold_left;
    gap = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) gap = rx_idle ? $urandom_range(0, 19) : 0;
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_beat(logic c, logic [3:0] v, logic a, logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= c;
    verb      <= v;
    arg_ok    <= a;
    body_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_cmd(logic [3:0] v, logic a);
    send_beat(1'b0, v, a, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_beat(1'b1, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), b);
  endtask

  task automatic send_body();
    int lines;
    int len;
    int kind;
    lines = $urandom_range(1, 4);
    repeat (lines) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        send_byte(CHAR_DOT);
      end else if (kind == 2) begin
        send_byte(CHAR_DOT);
        send_byte(CHAR_CR);
      end
      len = $urandom_range(0, 10);
      repeat (len) begin
        send_byte(($urandom_range(0, 7) == 0) ? CHAR_DOT : 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1)) send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end
    if ($urandom_range(0, 19) != 0) begin
      send_byte(CHAR_DOT);
      if ($urandom_range(0, 1)) send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end
  endtask

  task automatic send_session();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 1)) send_cmd(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1)));
        else send_byte(8'($urandom_range(0, 255)));
      end
      return;
    end
    send_cmd($urandom_range(0, 1) ? VERB_HELO : VERB_EHLO, 1'($urandom_range(0, 9) != 0));
    if ($urandom_range(0, 4) == 0) begin
      send_cmd($urandom_range(0, 1) ? VERB_XFWD_NAME : VERB_XFWD_PROT,
               1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(1, 2)) begin
      send_cmd(VERB_MAIL, 1'($urandom_range(0, 11) != 0));
      if ($urandom_range(0, 9) == 0) send_cmd(VERB_MAIL, 1'b1);
      n = $urandom_range(0, 4);
      repeat (n) begin
        kind = $urandom_range(0, 11);
        if (kind == 0) send_cmd(VERB_NOOP, 1'($urandom_range(0, 1)));
        else if (kind == 1) send_cmd(VERB_EMPTY, 1'($urandom_range(0, 1)));
        else if (kind == 2) send_cmd(VERB_UNKNOWN, 1'($urandom_range(0, 1)));
        send_cmd(VERB_RCPT, 1'($urandom_range(0, 9) != 0));
      end
      send_cmd(VERB_DATA, 1'($urandom_range(0, 1)));
      send_body();
    end
    if ($urandom_range(0, 3) == 0) send_cmd(VERB_RSET, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_commands();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_cmd(VERB_NOOP, 1'b0);
    send_cmd(VERB_EMPTY, 1'b1);
    send_cmd(VERB_UNKNOWN, 1'b1);
    send_cmd(VERB_UNASSIGNED, 1'b0);
    send_cmd(VERB_DATA, 1'b1);
    send_cmd(VERB_RCPT, 1'b1);
    send_byte(8'hFF);
    send_cmd(VERB_HELO, 1'b0);
    send_cmd(VERB_EHLO, 1'b1);
    send_cmd(VERB_XFWD_NAME, 1'b1);
    send_cmd(VERB_XFWD_PROT, 1'b0);
    send_cmd(VERB_MAIL, 1'b0);
    send_cmd(VERB_MAIL, 1'b1);
    send_cmd(VERB_MAIL, 1'b1);
    send_cmd(VERB_DATA, 1'b0);
    send_cmd(VERB_RCPT, 1'b0);
    send_cmd(VERB_RCPT, 1'b1);
    send_cmd(VERB_RCPT, 1'b1);
    send_cmd(VERB_HELO, 1'b1);
    send_cmd(VERB_RSET, 1'b0);
  endtask

  task automatic test_body();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_cmd(VERB_HELO, 1'b1);
    send_cmd(VERB_MAIL, 1'b1);
    send_cmd(VERB_RCPT, 1'b1);
    send_cmd(VERB_DATA, 1'b1);
    send_cmd(VERB_RSET, 1'b1);
    send_byte(CHAR_DOT);
    send_byte(CHAR_DOT);
    send_byte(8'h00);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_DOT);
    send_byte(CHAR_CR);
    send_byte(8'hFF);
    send_byte(CHAR_LF);
    send_byte(CHAR_DOT);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_cmd(VERB_MAIL, 1'b1);
    send_cmd(VERB_RCPT, 1'b1);
    send_cmd(VERB_DATA, 1'b1);
    send_byte(CHAR_DOT);
    send_byte(CHAR_LF);
    send_cmd(VERB_RSET, 1'b1);
  endtask

  task automatic test_rcpt_saturation();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_cmd(VERB_HELO, 1'b1);
    send_cmd(VERB_MAIL, 1'b1);
    repeat (RCPT_CAP + 4) send_cmd(VERB_RCPT, 1'b1);
    send_cmd(VERB_DATA, 1'b1);
    send_byte(CHAR_DOT);
    send_byte(CHAR_LF);
    send_cmd(VERB_EHLO, 1'b1);
    send_cmd(VERB_RSET, 1'b1);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_req = HOLD_CYCLES;
    repeat (3) send_session();
  endtask

  task automatic test_random();
    int mode;
    while (sent_count < ITEM_TARGET) begin
      mode = $urandom_range(0, 3);
      tx_idle = mode[0];
      rx_idle = mode[1];
      send_session();
    end
  endtask

  task automatic test_quit();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // close any open body so that QUIT is taken as a command
    send_byte(CHAR_LF);
    send_byte(CHAR_DOT);
    send_byte(CHAR_LF);
    send_cmd(VERB_QUIT, 1'b0);
    send_cmd(VERB_HELO, 1'b1);
    send_byte(CHAR_DOT);
    send_cmd(VERB_QUIT, 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_commands();
    test_body();
    test_rcpt_saturation();
    test_backpressure();
    test_random();
    test_quit();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
